/* hw/rtl/kpdf_pkg.sv */
// key press defer filter: shared constants, codes and types
// no dependencies; compiled first

package kpdf_pkg;

   // field widths of the channel words
   localparam int ACTION_W   = 2;
   localparam int POS_W      = 6;
   localparam int AGE_W      = 10;
   localparam int WINDOW_W   = 10;
   localparam int MODS_W     = 7;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 64;

   // defaults for the top level parameters
   localparam int NUM_POSITIONS_DEF = 64;
   localparam int TIMER_BITS_DEF    = 10;

   // result queue, power of two
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_CNT_W      = RSP_PTR_W + 1;

   localparam logic [WINDOW_W-1:0] DEFER_WINDOW_RESET = WINDOW_W'(50);
   localparam logic [MODS_W-1:0]   MODS_MAX           = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PRESS   = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEFER_WINDOW  = 1'd0,
      CSR_MODIFIER_MASK = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [POS_W-1:0]    position;
      logic [AGE_W-1:0]    age;
   } req_item_type;

   typedef struct packed {
      logic [POS_W-1:0] out_position;
      logic             out_pressed;
      logic             last;
   } rsp_word_type;

   // words produced by one item, first goes out first
   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } rsp_push_type;

endpackage

/* hw/rtl/kpdf_if.sv */
// key press defer filter: request and response channel interfaces
// depends on kpdf_pkg for field widths

interface kpdf_req_if import kpdf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [POS_W-1:0]    position;
   logic [AGE_W-1:0]    age;

   modport source (output valid, action, position, age, input ready);
   modport sink   (input valid, action, position, age, output ready);
endinterface

interface kpdf_rsp_if import kpdf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] out_position;
   logic             out_pressed;
   logic             last;

   modport source (output valid, out_position, out_pressed, last, input ready);
   modport sink   (input valid, out_position, out_pressed, last, output ready);
endinterface

/* hw/rtl/kpdf_core.sv */
// key press defer filter: input register, filter state and event decision
// depends on kpdf_pkg; feeds kpdf_fifo with up to two words per item

module kpdf_core import kpdf_pkg::*; #(
   parameter int NUM_POSITIONS = NUM_POSITIONS_DEF,
   parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  req_item_type             item,
   input  logic [WINDOW_W-1:0]      defer_window,
   input  logic [NUM_POSITIONS-1:0] modifier_mask,
   output logic                     item_valid,
   output rsp_push_type             push
);

   localparam int IDX_W = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
   localparam int SAT_W = (TIMER_BITS > WINDOW_W) ? TIMER_BITS : WINDOW_W;
   localparam logic [SAT_W-1:0] COUNT_MAX = SAT_W'((1 << TIMER_BITS) - 1);

   req_item_type          item_ff;
   logic                  item_valid_ff;
   logic                  buf_valid_ff, buf_valid_in;
   logic [POS_W-1:0]      buf_pos_ff, buf_pos_in;
   logic [TIMER_BITS-1:0] countdown_ff, countdown_in;
   logic [MODS_W-1:0]     mods_ff, mods_in;

   logic                  in_range;
   logic                  is_mod;
   logic [WINDOW_W-1:0]   remain;
   logic [SAT_W-1:0]      remain_wide;
   logic [TIMER_BITS-1:0] countdown_load;
   logic                  flush_valid;
   logic                  ev_valid;
   logic                  ev_pressed;
   rsp_word_type          flush_word;
   rsp_word_type          ev_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= take;
      end
      if (take) begin
         item_ff <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         buf_pos_ff   <= '0;
         countdown_ff <= '0;
         mods_ff      <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         buf_pos_ff   <= buf_pos_in;
         countdown_ff <= countdown_in;
         mods_ff      <= mods_in;
      end
   end

   // positions past the mask are regular keys
   assign in_range = ({1'b0, item_ff.position} < (POS_W + 1)'(NUM_POSITIONS));
   assign is_mod   = in_range && modifier_mask[item_ff.position[IDX_W-1:0]];

   assign remain         = defer_window - item_ff.age;
   assign remain_wide    = SAT_W'(remain);
   assign countdown_load = (remain_wide > COUNT_MAX) ? '1 : remain_wide[TIMER_BITS-1:0];

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_pos_in   = buf_pos_ff;
      countdown_in = countdown_ff;
      mods_in      = mods_ff;
      flush_valid  = 1'b0;
      ev_valid     = 1'b0;
      ev_pressed   = 1'b0;
      if (item_valid_ff) begin
         unique case (action_type'(item_ff.action))
            ACT_PRESS: begin
               ev_valid   = 1'b1;
               ev_pressed = 1'b1;
               if (is_mod) begin
                  if (mods_ff != MODS_MAX) begin
                     mods_in = mods_ff + 1'b1;
                  end
                  if (buf_valid_ff) begin
                     countdown_in = TIMER_BITS'(1);
                  end
               end else begin
                  // any buffered press goes out first
                  flush_valid  = buf_valid_ff;
                  buf_valid_in = 1'b0;
                  if (buf_valid_ff) begin
                     countdown_in = '0;
                  end
                  if (mods_ff == '0 && item_ff.age < defer_window) begin
                     ev_valid     = 1'b0;
                     buf_valid_in = 1'b1;
                     buf_pos_in   = item_ff.position;
                     countdown_in = countdown_load;
                  end
               end
            end
            ACT_RELEASE: begin
               ev_valid = 1'b1;
               if (is_mod) begin
                  if (mods_ff != '0) begin
                     mods_in = mods_ff - 1'b1;
                  end
               end else if (buf_valid_ff && buf_pos_ff == item_ff.position) begin
                  flush_valid  = 1'b1;
                  buf_valid_in = 1'b0;
                  countdown_in = '0;
               end
            end
            ACT_TICK: begin
               if (buf_valid_ff) begin
                  if (countdown_ff <= TIMER_BITS'(1)) begin
                     flush_valid  = 1'b1;
                     buf_valid_in = 1'b0;
                     countdown_in = '0;
                  end else begin
                     countdown_in = countdown_ff - 1'b1;
                  end
               end
            end
            ACT_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      flush_word.out_position = buf_pos_ff;
      flush_word.out_pressed  = 1'b1;
      flush_word.last         = !ev_valid;
      ev_word.out_position    = item_ff.position;
      ev_word.out_pressed     = ev_pressed;
      ev_word.last            = 1'b1;
      push.count  = 2'(flush_valid) + 2'(ev_valid);
      push.first  = flush_valid ? flush_word : ev_word;
      push.second = ev_word;
   end

   assign item_valid = item_valid_ff;

endmodule

/* hw/rtl/kpdf_fifo.sv */
// key press defer filter: result queue, two writes and one read per cycle
// depends on kpdf_pkg; drives the response channel

module kpdf_fifo import kpdf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  rsp_push_type         push,
   output logic [RSP_CNT_W-1:0] level,
   kpdf_rsp_if.source           rsp_chan
);

   rsp_word_type             entry_ff [RSP_FIFO_DEPTH];
   logic [RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]     count_ff, count_in;
   logic [RSP_PTR_W-1:0]     wr_ptr_next;
   logic                     pop;
   rsp_word_type             head;

   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign pop         = rsp_chan.valid && rsp_chan.ready;
   assign wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in    = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   assign head                  = entry_ff[rd_ptr_ff];
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.out_position = head.out_position;
   assign rsp_chan.out_pressed  = head.out_pressed;
   assign rsp_chan.last         = head.last;
   assign level                 = count_ff;

endmodule

/* hw/rtl/key_press_defer_filter_unit.sv */
// key press defer filter, top level: config registers, core and result queue
// depends on kpdf_pkg, kpdf_if, kpdf_core and kpdf_fifo
//
//  channel   | dir | payload                             | handshake
//  ----------+-----+-------------------------------------+--------------------
//  req_chan  | in  | action, position, age               | valid / ready
//  rsp_chan  | out | out_position, out_pressed, last     | valid / ready
//  csr_*     | in  | csr_index, csr_wdata                | csr_we, no wait
//
// one word is accepted per cycle while req ready is high; it is held in the input register,
// is decided against the filter state, and its zero to two result words land
// in an eight entry result queue, which feeds rsp_chan from its head entry
// req ready follows the queue level and the input register only, so a stalled
// rsp side never reaches req ready in the same cycle; ready drops when the
// queue could not take two more words from each item in flight
// reset is synchronous: buffer, countdown, modifier count and queue clear,
// defer window returns to 50 ticks and the modifier mask to zero

module key_press_defer_filter_unit import kpdf_pkg::*; #(
   parameter int NUM_POSITIONS = NUM_POSITIONS_DEF,
   parameter int TIMER_BITS    = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   kpdf_req_if.sink              req_chan,
   kpdf_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // config registers
   logic [WINDOW_W-1:0]      defer_window_ff;
   logic [NUM_POSITIONS-1:0] modifier_mask_ff;

   // core and queue hookup
   logic                     take;
   logic                     item_valid;
   req_item_type             item;
   rsp_push_type             push;
   logic [RSP_CNT_W-1:0]     level;
   logic [RSP_CNT_W:0]       level_worst;

   always_ff @(posedge clock) begin
      if (reset) begin
         defer_window_ff  <= DEFER_WINDOW_RESET;
         modifier_mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEFER_WINDOW:  defer_window_ff  <= csr_wdata[WINDOW_W-1:0];
            CSR_MODIFIER_MASK: modifier_mask_ff <= csr_wdata[NUM_POSITIONS-1:0];
            default: begin
            end
         endcase
      end
   end

   // worst case fill: queue level, plus two for the item in the input register
   assign level_worst = {1'b0, level} + (item_valid ? (RSP_CNT_W + 1)'(2) : '0);
   // room for that plus two more from a word taken now
   assign req_chan.ready = (level_worst <= (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH - 2));
   assign take           = req_chan.valid && req_chan.ready;

   assign item.action   = req_chan.action;
   assign item.position = req_chan.position;
   assign item.age      = req_chan.age;

   kpdf_core #(
      .NUM_POSITIONS (NUM_POSITIONS),
      .TIMER_BITS    (TIMER_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .item          (item),
      .defer_window  (defer_window_ff),
      .modifier_mask (modifier_mask_ff),
      .item_valid    (item_valid),
      .push          (push)
   );

   kpdf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .level    (level),
      .rsp_chan (rsp_chan)
   );

endmodule
